>>> hdl/avt_pkg.sv
`timescale 1ns / 1ps

package avt_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned RowW     = 3 * CoefW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = RowW;
  localparam int unsigned FracBits = 12;

  // Identity matrix in Q4.12 on reset, no translation offset, points mode.
  localparam logic [RowW-1:0] RowOneRst   = 48'h0000_0000_1000;
  localparam logic [RowW-1:0] RowTwoRst   = 48'h0000_1000_0000;
  localparam logic [RowW-1:0] RowThreeRst = 48'h1000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_ONE     = 3'd0,
    CFG_ROW_TWO     = 3'd1,
    CFG_ROW_THREE   = 3'd2,
    CFG_OFFSET_X    = 3'd3,
    CFG_OFFSET_Y    = 3'd4,
    CFG_OFFSET_Z    = 3'd5,
    CFG_APPLY_TRANS = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [RowW-1:0]          row_one;
    logic [RowW-1:0]          row_two;
    logic [RowW-1:0]          row_three;
    logic signed [CoordW-1:0] offset_x;
    logic signed [CoordW-1:0] offset_y;
    logic signed [CoordW-1:0] offset_z;
    logic                     apply_translation;
  } cfg_t;

endpackage

>>> hdl/avt_vec_in_if.sv
`timescale 1ns / 1ps

interface avt_vec_in_if;
  import avt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] in_x;
  logic signed [CoordW-1:0] in_y;
  logic signed [CoordW-1:0] in_z;
  logic                     last_in;

  modport source (output valid, output in_x, output in_y, output in_z, output last_in,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input last_in,
                  output ready);
endinterface

>>> hdl/avt_vec_out_if.sv
`timescale 1ns / 1ps

interface avt_vec_out_if;
  import avt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic signed [CoordW-1:0] out_z;
  logic                     overflow;
  logic                     last_out;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output overflow, output last_out, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input overflow, input last_out, output ready);
endinterface

>>> hdl/affine_vertex_transform.sv
`timescale 1ns / 1ps

// Affine vertex transform: one Q16.16 vector in, one transformed vector out.
// vin_i carries in_x/in_y/in_z and last_in; vout_o returns out_x/out_y/out_z,
// the overflow flag and last_out. Both are valid/ready channels; a request
// moves on a clock edge with valid and ready high.
// The 3x3 Q4.12 matrix, the translation offsets and the point/normal select
// are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them
// only while no vector is in flight, and the block itself does not enforce it.
// Unknown indexes are ignored.
// Two register stages: input register, then result register.
// Throughput: one vector per cycle while the receiver keeps up; the multiply,
// sum, shift, offset and saturate path between the two stages is combinational.
// When the receiver stalls, the result register holds and the input register
// still takes one more vector; vin_i.ready drops only when both are full.
// Reset clears both stages and loads the identity matrix, zero offsets and
// translation enabled.
module affine_vertex_transform
  import avt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  avt_vec_in_if.sink          vin_i,
  avt_vec_out_if.source       vout_o
);

  cfg_t cfg;

  logic                     s1_valid_q;
  logic signed [CoordW-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic                     s1_last_q;
  logic                     s1_ready;

  logic                     s2_valid_q;
  logic signed [CoordW-1:0] s2_x_q, s2_y_q, s2_z_q;
  logic                     s2_ovf_q;
  logic                     s2_last_q;
  logic                     s2_ready;

  logic signed [CoordW-1:0] res_x, res_y, res_z;
  logic                     ovf_x, ovf_y, ovf_z;

  avt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign s2_ready    = !s2_valid_q || vout_o.ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign vin_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= vin_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vin_i.valid && s1_ready) begin
      s1_x_q    <= vin_i.in_x;
      s1_y_q    <= vin_i.in_y;
      s1_z_q    <= vin_i.in_z;
      s1_last_q <= vin_i.last_in;
    end
  end

  // column k uses coefficient k of each packed row
  avt_column u_col_x (
    .x_i          (s1_x_q),
    .y_i          (s1_y_q),
    .z_i          (s1_z_q),
    .m1_i         (cfg.row_one[CoefW-1:0]),
    .m2_i         (cfg.row_two[CoefW-1:0]),
    .m3_i         (cfg.row_three[CoefW-1:0]),
    .offset_i     (cfg.offset_x),
    .add_offset_i (cfg.apply_translation),
    .res_o        (res_x),
    .ovf_o        (ovf_x)
  );

  avt_column u_col_y (
    .x_i          (s1_x_q),
    .y_i          (s1_y_q),
    .z_i          (s1_z_q),
    .m1_i         (cfg.row_one[2*CoefW-1:CoefW]),
    .m2_i         (cfg.row_two[2*CoefW-1:CoefW]),
    .m3_i         (cfg.row_three[2*CoefW-1:CoefW]),
    .offset_i     (cfg.offset_y),
    .add_offset_i (cfg.apply_translation),
    .res_o        (res_y),
    .ovf_o        (ovf_y)
  );

  avt_column u_col_z (
    .x_i          (s1_x_q),
    .y_i          (s1_y_q),
    .z_i          (s1_z_q),
    .m1_i         (cfg.row_one[3*CoefW-1:2*CoefW]),
    .m2_i         (cfg.row_two[3*CoefW-1:2*CoefW]),
    .m3_i         (cfg.row_three[3*CoefW-1:2*CoefW]),
    .offset_i     (cfg.offset_z),
    .add_offset_i (cfg.apply_translation),
    .res_o        (res_z),
    .ovf_o        (ovf_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_x_q    <= res_x;
      s2_y_q    <= res_y;
      s2_z_q    <= res_z;
      s2_ovf_q  <= ovf_x || ovf_y || ovf_z;
      s2_last_q <= s1_last_q;
    end
  end

  assign vout_o.valid    = s2_valid_q;
  assign vout_o.out_x    = s2_x_q;
  assign vout_o.out_y    = s2_y_q;
  assign vout_o.out_z    = s2_z_q;
  assign vout_o.overflow = s2_ovf_q;
  assign vout_o.last_out = s2_last_q;

  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vin_i.valid && vin_i.ready |=> s1_valid_q)
    else $error("accepted request not held in input stage");

  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> s2_valid_q)
    else $error("input stage did not advance into result register");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && !vout_o.ready |-> !vin_i.ready)
    else $error("request taken while both stages are full and stalled");

endmodule

>>> hdl/avt_cfg_regs.sv
`timescale 1ns / 1ps

module avt_cfg_regs
  import avt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_ONE:     cfg_d.row_one           = cfg_data_i[RowW-1:0];
        CFG_ROW_TWO:     cfg_d.row_two           = cfg_data_i[RowW-1:0];
        CFG_ROW_THREE:   cfg_d.row_three         = cfg_data_i[RowW-1:0];
        CFG_OFFSET_X:    cfg_d.offset_x          = cfg_data_i[CoordW-1:0];
        CFG_OFFSET_Y:    cfg_d.offset_y          = cfg_data_i[CoordW-1:0];
        CFG_OFFSET_Z:    cfg_d.offset_z          = cfg_data_i[CoordW-1:0];
        CFG_APPLY_TRANS: cfg_d.apply_translation = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_one           <= RowOneRst;
      cfg_q.row_two           <= RowTwoRst;
      cfg_q.row_three         <= RowThreeRst;
      cfg_q.offset_x          <= '0;
      cfg_q.offset_y          <= '0;
      cfg_q.offset_z          <= '0;
      cfg_q.apply_translation <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/avt_column.sv
`timescale 1ns / 1ps

module avt_column
  import avt_pkg::*;
(
  input  logic signed [CoordW-1:0] x_i,
  input  logic signed [CoordW-1:0] y_i,
  input  logic signed [CoordW-1:0] z_i,
  input  logic signed [CoefW-1:0]  m1_i,
  input  logic signed [CoefW-1:0]  m2_i,
  input  logic signed [CoefW-1:0]  m3_i,
  input  logic signed [CoordW-1:0] offset_i,
  input  logic                     add_offset_i,
  output logic signed [CoordW-1:0] res_o,
  output logic                     ovf_o
);

  localparam int unsigned ProdW = CoordW + CoefW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned ShrW  = SumW - FracBits;
  localparam int unsigned TotW  = ShrW + 1;

  logic signed [ProdW-1:0] p1, p2, p3;
  logic signed [SumW-1:0]  sum;
  logic signed [ShrW-1:0]  shr;
  logic signed [TotW-1:0]  off_ext;
  logic signed [TotW-1:0]  tot;
  logic                    fits;

  assign p1 = x_i * m1_i;
  assign p2 = y_i * m2_i;
  assign p3 = z_i * m3_i;

  assign sum = {{2{p1[ProdW-1]}}, p1} + {{2{p2[ProdW-1]}}, p2} + {{2{p3[ProdW-1]}}, p3};

  // dropping the fraction bits of a two's complement value floors it
  assign shr = sum[SumW-1:FracBits];

  assign off_ext = add_offset_i ? {{(TotW-CoordW){offset_i[CoordW-1]}}, offset_i} : '0;
  assign tot     = {shr[ShrW-1], shr} + off_ext;

  // in range when every bit above the result's sign matches it
  assign fits = (tot[TotW-1:CoordW-1] == '0) || (tot[TotW-1:CoordW-1] == '1);

  always_comb begin
    if (fits) begin
      res_o = tot[CoordW-1:0];
    end else if (tot[TotW-1]) begin
      res_o = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  assign ovf_o = !fits;

endmodule

>>> test/affine_vertex_transform_tb.sv
`timescale 1ns / 1ps

module affine_vertex_transform_tb
  import avt_pkg::*;
();

  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;
  localparam longint CoordMax = 64'sd2147483647;
  localparam longint CoordMin = -CoordMax - 1;
  localparam int     NumBlocks = 19;
  localparam int     BlockLen  = 100;

  typedef struct {
    logic signed [CoordW-1:0] coord [3];
    logic                     overflow;
    logic                     last;
  } vertex_t;

  class vertex_scoreboard;
    logic [RowW-1:0]          rows [3];
    logic signed [CoordW-1:0] offsets [3];
    logic                     translate;
    vertex_t                  pending_vertices [$];
    int                       mismatches;

    function new();
      rows[0]    = RowOneRst;
      rows[1]    = RowTwoRst;
      rows[2]    = RowThreeRst;
      offsets    = '{default: '0};
      translate  = 1'b1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_ROW_ONE:     rows[0] = data[RowW-1:0];
        CFG_ROW_TWO:     rows[1] = data[RowW-1:0];
        CFG_ROW_THREE:   rows[2] = data[RowW-1:0];
        CFG_OFFSET_X:    offsets[0] = data[CoordW-1:0];
        CFG_OFFSET_Y:    offsets[1] = data[CoordW-1:0];
        CFG_OFFSET_Z:    offsets[2] = data[CoordW-1:0];
        CFG_APPLY_TRANS: translate = data[0];
        default: ;
      endcase
    endfunction

    // Column c of the output takes column c of the 3x3 part plus offset c.
    function void note_request(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                               logic signed [CoordW-1:0] z, logic last);
      vertex_t v;
      longint  acc;
      longint  inp [3];
      inp[0]     = x;
      inp[1]     = y;
      inp[2]     = z;
      v.overflow = 1'b0;
      v.last     = last;
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int r = 0; r < 3; r++) begin
          acc += inp[r] * longint'($signed(rows[r][CoefW*c +: CoefW]));
        end
        acc = acc >>> FracBits;
        if (translate) begin
          acc += offsets[c];
        end
        if (acc > CoordMax) begin
          acc        = CoordMax;
          v.overflow = 1'b1;
        end else if (acc < CoordMin) begin
          acc        = CoordMin;
          v.overflow = 1'b1;
        end
        v.coord[c] = acc[CoordW-1:0];
      end
      pending_vertices.push_back(v);
    endfunction

    function void check_vertex(vertex_t act);
      vertex_t exp_v;
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d ovf=%0b last=%0b", $realtime,
                   act.coord[0], act.coord[1], act.coord[2], act.overflow, act.last);
        end
        return;
      end
      exp_v = pending_vertices.pop_front();
      if (act.coord[0] !== exp_v.coord[0] || act.coord[1] !== exp_v.coord[1] ||
          act.coord[2] !== exp_v.coord[2] || act.overflow !== exp_v.overflow ||
          act.last !== exp_v.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp x=%0d y=%0d z=%0d ovf=%0b last=%0b", $realtime,
                   exp_v.coord[0], exp_v.coord[1], exp_v.coord[2], exp_v.overflow,
                   exp_v.last);
          $display("%0t:          got x=%0d y=%0d z=%0d ovf=%0b last=%0b", $realtime,
                   act.coord[0], act.coord[1], act.coord[2], act.overflow, act.last);
        end
      end
    endfunction

    function int pending();
      return pending_vertices.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  vertex_scoreboard    sb;

  avt_vec_in_if  vin_if ();
  avt_vec_out_if vout_if ();

  affine_vertex_transform i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .vin_i      (vin_if),
    .vout_o     (vout_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("affine_vertex_transform_tb failed");
    $finish;
  end

  // ready is unknown only until the first falling edge, well inside reset
  always @(negedge clk_i) begin
    vout_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    vertex_t act;
    if (rst_ni && vout_if.valid && vout_if.ready) begin
      act.coord[0] = vout_if.out_x;
      act.coord[1] = vout_if.out_y;
      act.coord[2] = vout_if.out_z;
      act.overflow = vout_if.overflow;
      act.last     = vout_if.last_out;
      sb.check_vertex(act);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_vector(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                             logic [CoordW-1:0] z, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      vin_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    vin_if.valid   <= 1'b1;
    vin_if.in_x    <= x;
    vin_if.in_y    <= y;
    vin_if.in_z    <= z;
    vin_if.last_in <= last;
    do @(posedge clk_i); while (!vin_if.ready);
    sb.note_request(x, y, z, last);
    @(negedge clk_i);
  endtask

  task automatic drain();
    vin_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_one(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Bits above each register's width carry junk; the block must drop them.
  task automatic program_matrix(cfg_t c);
    write_one(CFG_ROW_ONE, c.row_one);
    write_one(CFG_ROW_TWO, c.row_two);
    write_one(CFG_ROW_THREE, c.row_three);
    write_one(CFG_OFFSET_X, {16'($urandom), c.offset_x});
    write_one(CFG_OFFSET_Y, {16'($urandom), c.offset_y});
    write_one(CFG_OFFSET_Z, {16'($urandom), c.offset_z});
    write_one(CFG_APPLY_TRANS, {$urandom, 15'($urandom), c.apply_translation});
    write_one(CfgUnusedIdx, {16'($urandom), 32'($urandom)});
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [CoefW-1:0] random_coef();
    case ($urandom_range(5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h1000;
      3:       return 16'($urandom_range(16'h2000)) - 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CoordW-1:0] random_coord();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
      default: return 32'($urandom);
    endcase
  endfunction

  initial begin
    cfg_t cfg;
    sb                = new();
    send_idle_pct     = 13;
    recv_idle_pct     = 71;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    vin_if.valid      = 1'b0;
    vin_if.in_x       = '0;
    vin_if.in_y       = '0;
    vin_if.in_z       = '0;
    vin_if.last_in    = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // identity matrix out of reset
    send_vector(32'h0, 32'h0, 32'h0, 1'b0);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_vector(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 1'b0);
    drain();

    // x column saturates, y column shows the floor on negatives,
    // z column uses the most negative coefficients
    cfg.row_one           = {16'h8000, 16'h0001, 16'h7FFF};
    cfg.row_two           = {16'h7FFF, 16'h0000, 16'h7FFF};
    cfg.row_three         = {16'h8000, 16'h0000, 16'h7FFF};
    cfg.offset_x          = 32'h7FFF_FFFF;
    cfg.offset_y          = 32'h0;
    cfg.offset_z          = 32'h8000_0000;
    cfg.apply_translation = 1'b1;
    for (int pass = 0; pass < 2; pass++) begin
      program_matrix(cfg);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_vector(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
      send_vector(32'h0000_0001, 32'h0, 32'h0, 1'b0);
      send_vector(32'hFFFF_EFFF, 32'h0000_0005, 32'hFFFF_FFFB, 1'b1);
      send_vector(32'h0, 32'h0, 32'h0, 1'b0);
      send_vector(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b1);
      drain();
      // second pass: normals, offsets dropped
      cfg.apply_translation = 1'b0;
    end

    for (int blk = 0; blk < NumBlocks; blk++) begin
      if (blk == NumBlocks / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 13;
      end else if (blk == 2 * NumBlocks / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cfg.row_one           = {random_coef(), random_coef(), random_coef()};
      cfg.row_two           = {random_coef(), random_coef(), random_coef()};
      cfg.row_three         = {random_coef(), random_coef(), random_coef()};
      cfg.offset_x          = random_coord();
      cfg.offset_y          = random_coord();
      cfg.offset_z          = random_coord();
      cfg.apply_translation = 1'($urandom_range(1));
      program_matrix(cfg);
      for (int n = 0; n < BlockLen; n++) begin
        send_vector(random_coord(), random_coord(), random_coord(),
                    $urandom_range(7) == 0);
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("affine_vertex_transform_tb passed");
    end else begin
      $display("affine_vertex_transform_tb failed");
    end
    $finish;
  end

endmodule
